/* sv/bdq_pkg.sv */
// Shared types, constants and a helper function for the bounded deque with search.
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int MODE_W = 3;
  localparam int VAL_W = 32;
  localparam int STAT_W = 2;
  localparam int POS_W = 4;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam mode_t MODE_INS_FRONT = 3'd0;
  localparam mode_t MODE_INS_BACK = 3'd1;
  localparam mode_t MODE_REM_FRONT = 3'd2;
  localparam mode_t MODE_REM_BACK = 3'd3;
  localparam mode_t MODE_SEARCH = 3'd4;

  localparam stat_t ST_OK = 2'd0;
  localparam stat_t ST_FULL = 2'd1;
  localparam stat_t ST_EMPTY = 2'd2;
  localparam stat_t ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SRCH = 2'b10
  } state_t;

  // Ring slot at a given offset from the base; the offset is at most DEPTH.
  function automatic ptr_t ring_slot(ptr_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

/* sv/bdq_in_if.sv */
// Command channel of the bounded deque: mode and value with a valid/ready handshake.
interface bdq_in_if;
  logic valid;
  logic ready;
  bdq_pkg::mode_t mode;
  bdq_pkg::val_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

/* sv/bdq_out_if.sv */
// Result channel of the bounded deque: status and position with a valid/ready handshake.
interface bdq_out_if;
  logic valid;
  logic ready;
  bdq_pkg::stat_t status;
  bdq_pkg::pos_t position;

  modport source (output valid, output status, output position, input ready);
  modport sink (input valid, input status, input position, output ready);
endinterface

/* sv/bounded_deque_with_search.sv */
// Bounded double-ended queue of signed words in a ring store, with a linear search.
//
// Each command word yields exactly one result word. Inserts and removes finish
// at the accepting edge and show their result in the next cycle. A search walks
// the stored entries from the front through the single read port of the entry
// store, one compare per cycle, and stops at the first match or after the last
// stored entry; the block takes no new command while a search runs. A new command is taken
// while the previous result is being drained in the same cycle.
module bounded_deque_with_search (
  input logic clk,
  input logic rst_n,
  bdq_in_if.sink in_ch,
  bdq_out_if.source out_ch
);

  bdq_pkg::val_t entries_r [bdq_pkg::DEPTH];

  bdq_pkg::state_t state_r, state_nxt;
  bdq_pkg::ptr_t front_r, front_nxt;
  bdq_pkg::cnt_t cnt_r, cnt_nxt;
  bdq_pkg::cnt_t rd_idx_r, rd_idx_nxt;
  bdq_pkg::ptr_t cmp_idx_r, cmp_idx_nxt;
  logic cmp_vld_r, cmp_vld_nxt;
  bdq_pkg::val_t key_r, key_nxt;
  bdq_pkg::val_t rd_data_r;
  logic out_valid_r, out_valid_nxt;
  bdq_pkg::stat_t status_r, status_nxt;
  bdq_pkg::pos_t position_r, position_nxt;

  logic acc;
  logic wr_en;
  bdq_pkg::ptr_t wr_slot;
  logic rd_en;
  bdq_pkg::ptr_t rd_slot;
  logic full;
  logic empty;

  assign in_ch.ready = (state_r == bdq_pkg::S_IDLE) && (!out_valid_r || out_ch.ready);
  assign acc = in_ch.valid && in_ch.ready;
  assign full = (cnt_r == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign empty = (cnt_r == '0);

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.position = position_r;

  assign rd_slot = bdq_pkg::ring_slot(front_r, rd_idx_r);

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    cnt_nxt = cnt_r;
    rd_idx_nxt = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_vld_nxt = 1'b0;
    key_nxt = key_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt = status_r;
    position_nxt = position_r;
    wr_en = 1'b0;
    wr_slot = front_r;
    rd_en = 1'b0;
    case (state_r)
      bdq_pkg::S_IDLE: begin
        if (acc) begin
          out_valid_nxt = 1'b1;
          status_nxt = bdq_pkg::ST_OK;
          position_nxt = '0;
          case (in_ch.mode)
            bdq_pkg::MODE_INS_FRONT: begin
              if (full) begin
                status_nxt = bdq_pkg::ST_FULL;
              end else begin
                front_nxt = bdq_pkg::ring_slot(front_r,
                                               bdq_pkg::CNT_W'(bdq_pkg::DEPTH - 1));
                wr_en = 1'b1;
                wr_slot = front_nxt;
                cnt_nxt = cnt_r + bdq_pkg::cnt_t'(1);
              end
            end
            bdq_pkg::MODE_INS_BACK: begin
              if (full) begin
                status_nxt = bdq_pkg::ST_FULL;
              end else begin
                wr_en = 1'b1;
                wr_slot = bdq_pkg::ring_slot(front_r, cnt_r);
                cnt_nxt = cnt_r + bdq_pkg::cnt_t'(1);
              end
            end
            bdq_pkg::MODE_REM_FRONT: begin
              if (empty) begin
                status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                front_nxt = bdq_pkg::ring_slot(front_r, bdq_pkg::CNT_W'(1));
                cnt_nxt = cnt_r - bdq_pkg::cnt_t'(1);
              end
            end
            bdq_pkg::MODE_REM_BACK: begin
              if (empty) begin
                status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - bdq_pkg::cnt_t'(1);
              end
            end
            bdq_pkg::MODE_SEARCH: begin
              out_valid_nxt = 1'b0;
              key_nxt = in_ch.value;
              rd_idx_nxt = '0;
              state_nxt = bdq_pkg::S_SRCH;
            end
            default: begin
            end
          endcase
        end
      end
      bdq_pkg::S_SRCH: begin
        if (cmp_vld_r && (rd_data_r == key_r)) begin
          out_valid_nxt = 1'b1;
          status_nxt = bdq_pkg::ST_OK;
          position_nxt = bdq_pkg::POS_W'(cmp_idx_r);
          state_nxt = bdq_pkg::S_IDLE;
        end else if (rd_idx_r == cnt_r) begin
          out_valid_nxt = 1'b1;
          status_nxt = bdq_pkg::ST_NOTFOUND;
          position_nxt = '0;
          state_nxt = bdq_pkg::S_IDLE;
        end else begin
          rd_en = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[bdq_pkg::PTR_W-1:0];
          rd_idx_nxt = rd_idx_r + bdq_pkg::cnt_t'(1);
        end
      end
      default: begin
        state_nxt = bdq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_slot] <= in_ch.value;
    end
    if (rd_en) begin
      rd_data_r <= entries_r[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::S_IDLE;
      front_r <= '0;
      cnt_r <= '0;
      cmp_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      cnt_r <= cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    key_r <= key_nxt;
    status_r <= status_nxt;
    position_r <= position_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    else $error("Fill count exceeds the store depth.");

  a_cnt_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> $past(acc))
    else $error("Fill count changed without an accepted word.");

  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bdq_pkg::S_SRCH) |-> (rd_idx_r <= cnt_r))
    else $error("Search index ran past the fill count.");

  a_search_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bdq_pkg::S_SRCH) && (state_nxt == bdq_pkg::S_IDLE) |=> out_valid_r)
    else $error("Search finished without a result word.");

  a_position_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (position_r != '0) |-> (status_r == bdq_pkg::ST_OK))
    else $error("Nonzero position with a failing status.");

endmodule

/* verif/tb_bounded_deque_with_search.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the bounded deque with search, with its own deque predictor.
module tb_bounded_deque_with_search;

  localparam bdq_pkg::mode_t MODE_SPARE_A = 3'd5;
  localparam bdq_pkg::mode_t MODE_SPARE_B = 3'd6;
  localparam bdq_pkg::mode_t MODE_SPARE_C = 3'd7;
  localparam int RANDOM_CMDS = 600;
  localparam int STALL_CYCLES = 250;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 4 * bdq_pkg::DEPTH;

  typedef struct {
    bdq_pkg::mode_t mode;
    bdq_pkg::val_t value;
    bit wait_drain;
  } deque_cmd_t;

  typedef struct {
    bdq_pkg::stat_t status;
    bdq_pkg::pos_t position;
  } deque_reply_t;

  logic clk;
  logic rst_n;

  bdq_in_if in_ch ();
  bdq_out_if out_ch ();

  bounded_deque_with_search uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  deque_cmd_t pending_cmds[$];
  deque_reply_t expected_replies[$];

  bdq_pkg::val_t model_slots[bdq_pkg::DEPTH];
  int model_head;
  int model_fill;

  int total_cmds;
  int cmds_sent;
  int mismatches;
  int cycle_count;
  int rx_hold;
  int stall_at;
  bit stall_done;
  bit accepted;
  deque_reply_t got_reply;

  function automatic deque_reply_t deque_reply(deque_cmd_t c);
    deque_reply_t r;
    bit hit;
    r.status = bdq_pkg::ST_OK;
    r.position = '0;
    hit = 1'b0;
    case (c.mode)
      bdq_pkg::MODE_INS_FRONT: begin
        if (model_fill >= bdq_pkg::DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
        end else begin
          model_head = (model_head + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH;
          model_slots[model_head] = c.value;
          model_fill++;
        end
      end
      bdq_pkg::MODE_INS_BACK: begin
        if (model_fill >= bdq_pkg::DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
        end else begin
          model_slots[(model_head + model_fill) % bdq_pkg::DEPTH] = c.value;
          model_fill++;
        end
      end
      bdq_pkg::MODE_REM_FRONT: begin
        if (model_fill == 0) begin
          r.status = bdq_pkg::ST_EMPTY;
        end else begin
          model_head = (model_head + 1) % bdq_pkg::DEPTH;
          model_fill--;
        end
      end
      bdq_pkg::MODE_REM_BACK: begin
        if (model_fill == 0) begin
          r.status = bdq_pkg::ST_EMPTY;
        end else begin
          model_fill--;
        end
      end
      bdq_pkg::MODE_SEARCH: begin
        for (int k = 0; k < model_fill; k++) begin
          if (!hit && model_slots[(model_head + k) % bdq_pkg::DEPTH] == c.value) begin
            hit = 1'b1;
            r.position = bdq_pkg::pos_t'(k);
          end
        end
        if (!hit) begin
          r.status = bdq_pkg::ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic add_cmd(bdq_pkg::mode_t m, bdq_pkg::val_t v, bit drain = 1'b0);
    deque_cmd_t c;
    c.mode = m;
    c.value = v;
    c.wait_drain = drain;
    pending_cmds.push_back(c);
  endtask

  function automatic bdq_pkg::val_t pick_value();
    bdq_pkg::val_t pool[8];
    pool = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1, 32'sh5A5A5A5A,
             32'shA5A5A5A5, 32'sd77};
    if ($urandom_range(99) < 60) begin
      return pool[$urandom_range(7)];
    end
    return bdq_pkg::val_t'($urandom);
  endfunction

  task automatic build_stimulus();
    bdq_pkg::mode_t spare[3];
    int r;
    bit fill_phase;
    spare = '{MODE_SPARE_A, MODE_SPARE_B, MODE_SPARE_C};

    add_cmd(bdq_pkg::MODE_SEARCH, 32'sd5);
    add_cmd(bdq_pkg::MODE_REM_FRONT, bdq_pkg::val_t'($urandom));
    add_cmd(bdq_pkg::MODE_REM_BACK, bdq_pkg::val_t'($urandom));
    add_cmd(bdq_pkg::MODE_INS_BACK, 32'sd123);
    add_cmd(bdq_pkg::MODE_REM_FRONT, bdq_pkg::val_t'($urandom));
    add_cmd(bdq_pkg::MODE_INS_FRONT, 32'sh80000000);
    add_cmd(bdq_pkg::MODE_INS_BACK, 32'sh7FFFFFFF);
    add_cmd(bdq_pkg::MODE_INS_BACK, -32'sd1);
    add_cmd(bdq_pkg::MODE_INS_FRONT, -32'sd1);
    add_cmd(bdq_pkg::MODE_SEARCH, -32'sd1);
    add_cmd(bdq_pkg::MODE_SEARCH, 32'sh7FFFFFFF);
    add_cmd(bdq_pkg::MODE_SEARCH, 32'sh0);
    add_cmd(MODE_SPARE_A, 32'sh7FFFFFFF);
    add_cmd(MODE_SPARE_C, 32'sh80000000);
    for (int k = 0; k < bdq_pkg::DEPTH - 4; k++) begin
      add_cmd((k % 2 == 0) ? bdq_pkg::MODE_INS_FRONT : bdq_pkg::MODE_INS_BACK,
              bdq_pkg::val_t'(1000 + k));
    end
    add_cmd(bdq_pkg::MODE_INS_FRONT, 32'sd9);
    add_cmd(bdq_pkg::MODE_INS_BACK, 32'sd9);
    add_cmd(bdq_pkg::MODE_SEARCH, bdq_pkg::val_t'(1000 + bdq_pkg::DEPTH - 5));

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      fill_phase = ((i / 40) % 2) == 1;
      r = $urandom_range(99);
      if (r < 3) begin
        add_cmd(spare[$urandom_range(2)], bdq_pkg::val_t'($urandom),
                i == 200 || i == 450);
      end else if (r < 23) begin
        add_cmd(bdq_pkg::MODE_SEARCH, pick_value(), i == 200 || i == 450);
      end else if (($urandom_range(99) < 75) == fill_phase) begin
        add_cmd($urandom_range(1) ? bdq_pkg::MODE_INS_FRONT : bdq_pkg::MODE_INS_BACK,
                pick_value(), i == 200 || i == 450);
      end else begin
        add_cmd($urandom_range(1) ? bdq_pkg::MODE_REM_FRONT : bdq_pkg::MODE_REM_BACK,
                bdq_pkg::val_t'($urandom), i == 200 || i == 450);
      end
    end
    total_cmds = pending_cmds.size();
    stall_at = total_cmds * 5 / 6;
  endtask

  function automatic int tx_idle_pct();
    int phase;
    phase = cmds_sent * 3 / total_cmds;
    return (phase == 0) ? 10 : (phase == 1) ? 86 : 0;
  endfunction

  function automatic int rx_idle_pct();
    int phase;
    phase = cmds_sent * 3 / total_cmds;
    return (phase == 0) ? 86 : (phase == 1) ? 10 : 0;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      accepted = in_ch.valid && in_ch.ready;
      if (accepted) begin
        expected_replies.push_back(deque_reply(pending_cmds[0]));
        void'(pending_cmds.pop_front());
        cmds_sent++;
      end
      if (in_ch.valid && !accepted) begin
      end else if (pending_cmds.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending_cmds[0].wait_drain && expected_replies.size() != 0) begin
        in_ch.valid <= 1'b0;
      end else if (rx_hold == 0 && $urandom_range(99) < tx_idle_pct()) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.mode <= pending_cmds[0].mode;
        in_ch.value <= pending_cmds[0].value;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (!stall_done && cmds_sent >= stall_at) begin
        rx_hold = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct());
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result word: status %0d, position %0d",
               out_ch.status, out_ch.position);
        mismatches++;
      end else begin
        got_reply = expected_replies.pop_front();
        if (out_ch.status !== got_reply.status) begin
          $error("status: expected %0d, actual %0d", got_reply.status, out_ch.status);
          mismatches++;
        end
        if (out_ch.position !== got_reply.position) begin
          $error("position: expected %0d, actual %0d", got_reply.position, out_ch.position);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = bdq_pkg::MODE_INS_FRONT;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    model_head = 0;
    model_fill = 0;
    cmds_sent = 0;
    mismatches = 0;
    cycle_count = 0;
    rx_hold = 0;
    stall_done = 1'b0;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() != 0 || expected_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
